/* sv/pss_pkg.sv */
`default_nettype none
package pss_pkg;
    typedef enum logic [2:0] {
        REQ_ALLOC   = 3'd0,
        REQ_PUSH    = 3'd1,
        REQ_POP     = 3'd2,
        REQ_DELETE  = 3'd3,
        REQ_READ    = 3'd4,
        REQ_SORTED  = 3'd5,
        REQ_RESIZE  = 3'd6,
        REQ_COUNT   = 3'd7
    } t_req;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_BAD_SLOT     = 4'd1,
        ST_BAD_SIZE     = 4'd2,
        ST_ALREADY      = 4'd3,
        ST_NOT_ALLOC    = 4'd4,
        ST_FULL         = 4'd5,
        ST_EMPTY        = 4'd6,
        ST_NOT_FOUND    = 4'd7,
        ST_BAD_NEW_SIZE = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_DEL,
        S_SORT,
        S_EMIT,
        S_RESP
    } t_state;
endpackage
`default_nettype wire

/* sv/partitioned_slot_stack_table_top.sv */
// channel | dir | tdata fields (low bit first)                  | tuser
// s_axis  | in  | slot[3:0], amount[11:4], value[43:12] (48 b)  | req_type[2:0]
// m_axis  | out | data_word[31:0], elem_count[38:32] (40 b)     | status[3:0], tlast = last
// one request at a time; a simple result is registered from the response state after its transfer
// delete walks the slot words through the element memory, one word per cycle
// read gives one word at a time, each held until taken; sorted read does a full selection
// pass over the slot per word, set by the single read port of the element memory
// synchronous active-low reset clears slot table; element memory is not cleared
// m_axis stall holds the result register; no new request is taken until done
`default_nettype none
module partitioned_slot_stack_table_top #(
    parameter int SLOTS    = 10,
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // slot, amount, value, zero fill
    input  wire logic [2:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // data_word, elem_count, zero fill
    output logic [3:0]       m_axis_tuser,  // status
    output logic             m_axis_tlast   // last
);
    import pss_pkg::*;

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DEP = SLOTS * CAPACITY;
    localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;

    // slot table, small and read at one index
    logic          r_alloc [SLOTS];
    logic [6:0]    r_cap   [SLOTS];
    logic [6:0]    r_cnt   [SLOTS];
    // element memory
    logic [31:0]   r_mem   [DEP];
    logic [31:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;

    t_state        r_state, n_state;
    t_req          r_req;
    logic [SW-1:0] r_s;
    logic [7:0]    r_amt;
    logic [31:0]   r_val;
    logic [AW-1:0] r_base;
    logic [6:0]    r_n, r_i, r_kept, r_emit, r_pick, r_epick;
    logic [31:0]   r_best, r_prev;
    logic          r_have, r_first;
    logic          r_ov;
    logic [3:0]    r_st;
    logic [31:0]   r_dw;
    logic [6:0]    r_oc;
    logic          r_ol;

    logic [3:0]    slot_in;
    logic          in_xfer, out_xfer;
    assign slot_in  = s_axis_tdata[3:0];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    // signed ordering key and sort candidate test
    logic [31:0] kx, bx, px;
    logic        above_prev, eq_prev, better, cand;
    assign kx = r_rdata ^ 32'h8000_0000;
    assign bx = r_best ^ 32'h8000_0000;
    assign px = r_prev ^ 32'h8000_0000;
    // candidates ordered by (value, index) strictly after the last emitted one
    assign eq_prev    = (kx == px);
    assign above_prev = r_first || (kx > px) || (eq_prev && (r_i - 7'd1) > r_epick);
    assign better     = !r_have || (kx < bx);
    assign cand       = above_prev && better;

    logic       sbad, sz_bad;
    logic [7:0] ncap;
    assign sbad   = (slot_in == 4'd0) || ({28'd0, slot_in} > SLOTS);
    assign ncap   = {1'b0, r_cap[r_s]} + r_amt;
    assign sz_bad = $signed(r_amt) < 8'sd1 || $signed(r_amt) > CAPACITY;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer && !sbad) n_state = S_RESP;
            S_RESP: begin
                if (r_alloc[r_s] && r_cnt[r_s] != 7'd0) begin
                    if (r_req == REQ_DELETE) n_state = S_DEL;
                    else if (r_req == REQ_READ) n_state = S_RD;
                    else if (r_req == REQ_SORTED) n_state = S_SORT;
                    else n_state = S_IDLE;
                end else n_state = S_IDLE;
            end
            S_DEL:  if (r_i == r_n + 7'd1) n_state = S_IDLE;
            S_RD:   if (!r_ov && r_i == r_n + 7'd1) n_state = S_IDLE;
            S_SORT: if (r_i == r_n + 7'd1) n_state = S_EMIT;
            S_EMIT: if (!r_ov) n_state = (r_emit + 7'd1 == r_n) ? S_IDLE : S_SORT;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_base + AW'(r_n);
        mem_wd = r_val;
        mem_ra = r_base + AW'(r_i[CW:0]);
        // a push only writes when it is accepted into the slot
        if (r_state == S_RESP && r_req == REQ_PUSH && r_alloc[r_s]
            && r_cnt[r_s] < r_cap[r_s]) begin
            mem_we = 1'b1;
            mem_wa = r_base + AW'(r_cnt[r_s]);
        end
        if (r_state == S_DEL && r_i != 7'd0 && r_i != r_n + 7'd1 && r_rdata != r_val) begin
            mem_we = 1'b1;
            mem_wa = r_base + AW'(r_kept);
            mem_wd = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_alloc[k] <= 1'b0;
                r_cap[k]   <= 7'd0;
                r_cnt[k]   <= 7'd0;
            end
        end else begin
            r_state <= n_state;
            if (out_xfer) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_xfer) begin
                    r_req  <= t_req'(s_axis_tuser);
                    r_amt  <= s_axis_tdata[11:4];
                    r_val  <= s_axis_tdata[43:12];
                    r_s    <= SW'(slot_in - 4'd1);
                    r_base <= AW'((slot_in - 4'd1) * CAPACITY);
                    r_i    <= 7'd0;
                    if (sbad) begin
                        r_ov <= 1'b1; r_st <= ST_BAD_SLOT; r_dw <= '0;
                        r_oc <= '0; r_ol <= 1'b1;
                    end
                end
                S_RESP: begin
                    r_n <= r_cnt[r_s]; r_kept <= '0; r_emit <= '0;
                    r_have <= 1'b0; r_first <= 1'b1; r_pick <= '0; r_epick <= '0;
                    r_dw <= '0; r_ol <= 1'b1; r_st <= ST_OK;
                    r_oc <= r_cnt[r_s];
                    r_ov <= 1'b1;
                    if (r_req == REQ_ALLOC) begin
                        if (sz_bad) r_st <= ST_BAD_SIZE;
                        else if (r_alloc[r_s]) r_st <= ST_ALREADY;
                        else begin
                            r_alloc[r_s] <= 1'b1;
                            r_cap[r_s] <= r_amt[6:0];
                            r_cnt[r_s] <= '0;
                            r_oc <= '0;
                        end
                    end else if (!r_alloc[r_s]) begin
                        r_st <= (r_req == REQ_COUNT) ? ST_EMPTY : ST_NOT_ALLOC;
                        r_oc <= '0;
                    end else begin
                        case (r_req)
                            REQ_PUSH: if (r_cnt[r_s] >= r_cap[r_s]) r_st <= ST_FULL;
                                else begin
                                    r_cnt[r_s] <= r_cnt[r_s] + 7'd1;
                                    r_oc <= r_cnt[r_s] + 7'd1;
                                end
                            REQ_POP: if (r_cnt[r_s] == 0) r_st <= ST_EMPTY;
                                else begin
                                    r_cnt[r_s] <= r_cnt[r_s] - 7'd1;
                                    r_oc <= r_cnt[r_s] - 7'd1;
                                end
                            REQ_DELETE, REQ_READ, REQ_SORTED:
                                if (r_cnt[r_s] == 0) r_st <= ST_EMPTY;
                                else r_ov <= 1'b0;
                            REQ_RESIZE:
                                if ($signed(ncap) < 8'sd1 || $signed(ncap) > CAPACITY)
                                    r_st <= ST_BAD_NEW_SIZE;
                                else begin
                                    r_cap[r_s] <= ncap[6:0];
                                    if (r_cnt[r_s] > ncap[6:0]) begin
                                        r_cnt[r_s] <= ncap[6:0];
                                        r_oc <= ncap[6:0];
                                    end
                                end
                            default: ;
                        endcase
                    end
                end
                S_DEL: begin
                    r_i <= r_i + 7'd1;
                    if (r_i != 7'd0 && r_rdata != r_val) r_kept <= r_kept + 7'd1;
                    if (r_i == r_n + 7'd1) begin
                        r_cnt[r_s] <= r_kept;
                        r_st <= (r_kept == r_n) ? ST_NOT_FOUND : ST_OK;
                        r_oc <= r_kept; r_ol <= 1'b1; r_dw <= '0; r_ov <= 1'b1;
                    end
                end
                S_RD: if (!r_ov && r_i != r_n + 7'd1) begin
                    // read index i issued, data arrives next cycle
                    r_i <= r_i + 7'd1;
                    if (r_i != 7'd0) begin
                        r_ov <= 1'b1; r_st <= ST_OK; r_dw <= r_rdata;
                        r_oc <= r_n; r_ol <= (r_i == r_n);
                        r_i <= r_i;
                        if (r_i == r_n) r_i <= r_n + 7'd1;
                    end
                end else if (out_xfer && r_i != r_n + 7'd1) begin
                    r_i <= r_i + 7'd1;
                end
                S_SORT: begin
                    r_i <= r_i + 7'd1;
                    if (r_i != 7'd0 && r_i != r_n + 7'd1 && cand) begin
                        r_have <= 1'b1; r_best <= r_rdata; r_pick <= r_i - 7'd1;
                    end
                end
                S_EMIT: if (!r_ov) begin
                    r_ov <= 1'b1; r_st <= ST_OK; r_dw <= r_best; r_oc <= r_n;
                    r_ol <= (r_emit + 7'd1 == r_n);
                    r_emit <= r_emit + 7'd1; r_prev <= r_best; r_epick <= r_pick;
                    r_first <= 1'b0; r_have <= 1'b0; r_i <= '0;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_oc, r_dw};
    assign m_axis_tuser  = r_st;
    assign m_axis_tlast  = r_ol;

    // no request is taken while a result still waits
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !s_axis_tready) else $error("input taken while result pending");
    // error results never carry data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_st != ST_OK) |-> (r_dw == 32'd0 && r_ol))
        else $error("error result with data");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> ($stable(r_dw) && $stable(r_st)))
        else $error("result changed under stall");
endmodule
`default_nettype wire
